/* hdl/scqe_pkg.sv */
// ----------------------------------------------------------------------------
// scqe_pkg
// Shared types, constants and helpers for the spatial cell query engine.
// ----------------------------------------------------------------------------
`default_nettype none
package scqe_pkg;

  localparam int unsigned ENTRY_DEPTH      = 4096;
  localparam int unsigned ID_DEPTH         = 65536;
  localparam int unsigned MAX_IDS_PER_CELL = 64;
  localparam int unsigned COORD_BITS       = 21;

  localparam int unsigned ENTRY_AW = $clog2(ENTRY_DEPTH);
  localparam int unsigned ID_AW    = $clog2(ID_DEPTH);
  localparam int unsigned KEY_W    = 63;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Input modes
  typedef enum logic [1:0] {
    MODE_WR_ENTRY = 2'd0,
    MODE_WR_ID    = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ID       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADRANGE = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BBOX_X    = 3'd0,
    CFG_BBOX_Y    = 3'd1,
    CFG_BBOX_Z    = 3'd2,
    CFG_CELL_SIZE = 3'd3,
    CFG_NUM_ENT   = 3'd4,
    CFG_NUM_IDS   = 3'd5
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_SETUP,
    S_DIV_RUN,
    S_KEY,
    S_SRCH_ADDR,
    S_SRCH_WAIT,
    S_SRCH_CMP,
    S_FETCH_WAIT,
    S_CHECK,
    S_ID_WAIT,
    S_EMIT,
    S_STATUS
  } state_t;

  // Control from sequencer to divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [31:0] id_out;
    logic [1:0]  status;
    logic        last;
    logic [62:0] key_out;
  } result_t;

  // Spread 21 bits to every third bit position
  function automatic logic [62:0] spread3(input logic [COORD_BITS-1:0] v);
    logic [62:0] r;
    r = '0;
    for (int i = 0; i < COORD_BITS; i++) r[3*i] = v[i];
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/scqe_if.sv */
// ----------------------------------------------------------------------------
// scqe_in_if / scqe_out_if
// Valid/ready channels for query-engine transactions.
// ----------------------------------------------------------------------------
`default_nettype none
interface scqe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] index;
  logic [62:0] cell_key;
  logic [15:0] id_start;
  logic [6:0]  id_run;
  logic [31:0] traj_id;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source (output valid, mode, index, cell_key, id_start, id_run, traj_id,
                  pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, mode, index, cell_key, id_start, id_run, traj_id,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface scqe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] id_out;
  logic [1:0]  status;
  logic        last;
  logic [62:0] key_out;
  modport source (output valid, id_out, status, last, key_out, input ready);
  modport sink   (input valid, id_out, status, last, key_out, output ready);
endinterface
`default_nettype wire

/* hdl/scqe_div.sv */
// ----------------------------------------------------------------------------
// scqe_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module scqe_div
  import scqe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // One shift-subtract step
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A result never appears without a run in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");

endmodule
`default_nettype wire

/* hdl/scqe_store.sv */
// ----------------------------------------------------------------------------
// scqe_store
// Cell table and ID store memories, one write and one registered read each.
// ----------------------------------------------------------------------------
`default_nettype none
module scqe_store
  import scqe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                ent_we,
  input  wire logic [ENTRY_AW-1:0] ent_waddr,
  input  wire logic [62:0]         ent_wkey,
  input  wire logic [15:0]         ent_wstart,
  input  wire logic [6:0]          ent_wrun,
  input  wire logic [ENTRY_AW-1:0] ent_raddr,
  output logic [62:0]              ent_rkey,
  output logic [15:0]              ent_rstart,
  output logic [6:0]               ent_rrun,
  input  wire logic                id_we,
  input  wire logic [ID_AW-1:0]    id_waddr,
  input  wire logic [31:0]         id_wdata,
  input  wire logic [ID_AW-1:0]    id_raddr,
  output logic [31:0]              id_rdata
);

  logic [62:0] key_mem   [ENTRY_DEPTH];
  logic [15:0] start_mem [ENTRY_DEPTH];
  logic [6:0]  run_mem   [ENTRY_DEPTH];
  logic [31:0] id_mem    [ID_DEPTH];

  // Cell table
  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_waddr]   <= ent_wkey;
      start_mem[ent_waddr] <= ent_wstart;
      run_mem[ent_waddr]   <= ent_wrun;
    end
    ent_rkey   <= key_mem[ent_raddr];
    ent_rstart <= start_mem[ent_raddr];
    ent_rrun   <= run_mem[ent_raddr];
  end

  // ID store
  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_wdata;
    id_rdata <= id_mem[id_raddr];
  end

endmodule
`default_nettype wire

/* hdl/spatial_cell_query_engine.sv */
// ----------------------------------------------------------------------------
// spatial_cell_query_engine
// Morton-key spatial lookup over a loaded, key-sorted cell table.
// ----------------------------------------------------------------------------
// Writes of table entries and IDs are done when accepted. A query works
// through its three axes one at a time. An axis with a non-positive offset,
// or any axis while the cell size is zero, skips the divider and gets cell
// zero. Every other axis goes through a setup state, then a run on the
// shared divider. A key state then builds the key. The binary search makes
// up to 13 probes, each through the address, wait and compare states at the
// registered table read port, plus a closing address state when the key is
// missing. After a hit, a check state follows, then each emitted ID passes
// a fetch state and an ID state (address, registered read) behind a single
// output register. A query yields one status result or up to 64 IDs, and
// the receiver can hold off each result. The block takes no new transaction
// until the last result of the current query has been taken.
// Software must load the entries in ascending key order.
`default_nettype none
module spatial_cell_query_engine
  import scqe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  scqe_in_if.sink                    in_ch,
  scqe_out_if.source                 out_ch
);

  // Configuration registers
  logic [31:0] bbox_r [3];
  logic [31:0] cell_size_r;
  logic [12:0] num_ent_r;
  logic [16:0] num_ids_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bbox_r[0]   <= '0;
      bbox_r[1]   <= '0;
      bbox_r[2]   <= '0;
      cell_size_r <= 32'd65536;
      num_ent_r   <= '0;
      num_ids_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BBOX_X:    bbox_r[0]   <= cfg_wdata;
        CFG_BBOX_Y:    bbox_r[1]   <= cfg_wdata;
        CFG_BBOX_Z:    bbox_r[2]   <= cfg_wdata;
        CFG_CELL_SIZE: cell_size_r <= cfg_wdata;
        CFG_NUM_ENT:   num_ent_r   <= cfg_wdata[12:0];
        CFG_NUM_IDS:   num_ids_r   <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // Saturated counts
  logic [13:0] ne_sat;
  logic [17:0] ni_sat;
  assign ne_sat = ({1'b0, num_ent_r} > 14'(ENTRY_DEPTH)) ? 14'(ENTRY_DEPTH) : {1'b0, num_ent_r};
  assign ni_sat = ({1'b0, num_ids_r} > 18'(ID_DEPTH)) ? 18'(ID_DEPTH) : {1'b0, num_ids_r};

  state_t state_r, state_nxt;

  logic signed [31:0] pos_r [3];
  logic [1:0]  axis_r, axis_nxt;
  logic [20:0] cell_r [3];
  logic [20:0] cell_nxt;
  logic        cell_we;
  logic [62:0] key_r, key_nxt;
  logic [13:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [15:0] start_r, start_nxt;
  logic [6:0]  run_r, run_nxt, cnt_r, cnt_nxt;
  status_t     st_r, st_nxt;
  logic [32:0] diff;
  logic        diff_pos;
  div_req_t    dreq;
  div_rsp_t    drsp;
  result_t     res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        out_free;

  logic [62:0] ent_rkey;
  logic [15:0] ent_rstart;
  logic [6:0]  ent_rrun;
  logic [31:0] id_rdata;
  logic [ID_AW-1:0] id_raddr;

  logic accept;
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !ovalid_r || out_ch.ready;

  // Offset of current axis, 33-bit signed
  assign diff = {pos_r[axis_r][31], pos_r[axis_r]} - {bbox_r[axis_r][31], bbox_r[axis_r]};
  assign diff_pos = !diff[32] && (diff != '0);
  assign id_raddr = start_r + {9'd0, cnt_r};

  scqe_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  scqe_store u_store (
    .clk(clk),
    .ent_we(accept && in_ch.mode == MODE_WR_ENTRY && 17'(in_ch.index) < 17'(ENTRY_DEPTH)),
    .ent_waddr(ENTRY_AW'(in_ch.index)),
    .ent_wkey(in_ch.cell_key), .ent_wstart(in_ch.id_start), .ent_wrun(in_ch.id_run),
    .ent_raddr(ENTRY_AW'(mid_r)),
    .ent_rkey(ent_rkey), .ent_rstart(ent_rstart), .ent_rrun(ent_rrun),
    .id_we(accept && in_ch.mode == MODE_WR_ID && 25'(in_ch.index) < 25'(ID_DEPTH)),
    .id_waddr(ID_AW'(in_ch.index)), .id_wdata(in_ch.traj_id),
    .id_raddr(id_raddr), .id_rdata(id_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    cell_nxt   = '0;
    cell_we    = 1'b0;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    start_nxt  = start_r;
    run_nxt    = run_r;
    cnt_nxt    = cnt_r;
    st_nxt     = st_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    dreq.start    = 1'b0;
    dreq.dividend = diff[31:0];
    dreq.divisor  = cell_size_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.mode == MODE_QUERY) begin
          axis_nxt  = '0;
          state_nxt = S_DIV_SETUP;
        end
      end
      S_DIV_SETUP: begin
        if (cell_size_r == '0 || !diff_pos) begin
          cell_we = 1'b1;
          state_nxt = (axis_r == 2'd2) ? S_KEY : S_DIV_SETUP;
          axis_nxt  = axis_r + 2'd1;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        if (drsp.done) begin
          cell_we   = 1'b1;
          cell_nxt  = (drsp.quotient[31:21] != '0) ? '1 : drsp.quotient[20:0];
          state_nxt = (axis_r == 2'd2) ? S_KEY : S_DIV_SETUP;
          axis_nxt  = axis_r + 2'd1;
        end
      end
      S_KEY: begin
        key_nxt   = spread3(cell_r[0]) | (spread3(cell_r[1]) << 1)
                  | (spread3(cell_r[2]) << 2);
        lo_nxt    = '0;
        hi_nxt    = ne_sat;
        state_nxt = S_SRCH_ADDR;
      end
      S_SRCH_ADDR: begin
        if (lo_r < hi_r) begin
          mid_nxt   = lo_r + ((hi_r - 14'd1 - lo_r) >> 1);
          state_nxt = S_SRCH_WAIT;
        end else begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_STATUS;
        end
      end
      S_SRCH_WAIT: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (ent_rkey == key_r) begin
          start_nxt = ent_rstart;
          run_nxt   = ent_rrun;
          state_nxt = S_CHECK;
        end else if (ent_rkey < key_r) begin
          lo_nxt    = mid_r + 14'd1;
          state_nxt = S_SRCH_ADDR;
        end else begin
          hi_nxt    = mid_r;
          state_nxt = S_SRCH_ADDR;
        end
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (run_r == '0) begin
          st_nxt = ST_EMPTY;
          state_nxt = S_STATUS;
        end else if (run_r > 7'(MAX_IDS_PER_CELL) || {2'd0, start_r} >= ni_sat
                     || {2'd0, start_r} + {11'd0, run_r} > ni_sat) begin
          st_nxt = ST_BADRANGE;
          state_nxt = S_STATUS;
        end else begin
          state_nxt = S_FETCH_WAIT;
        end
      end
      S_FETCH_WAIT: state_nxt = S_ID_WAIT;
      S_ID_WAIT: begin
        if (out_free) begin
          res_nxt.id_out  = id_rdata;
          res_nxt.status  = ST_ID;
          res_nxt.last    = (cnt_r + 7'd1 == run_r);
          res_nxt.key_out = key_r;
          ovalid_nxt      = 1'b1;
          cnt_nxt         = cnt_r + 7'd1;
          state_nxt       = (cnt_r + 7'd1 == run_r) ? S_EMIT : S_FETCH_WAIT;
        end
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_STATUS: begin
        if (out_free) begin
          res_nxt.id_out  = '0;
          res_nxt.status  = st_r;
          res_nxt.last    = 1'b1;
          res_nxt.key_out = key_r;
          ovalid_nxt      = 1'b1;
          state_nxt       = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      axis_r   <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      axis_r   <= axis_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (accept) begin
      pos_r[0] <= in_ch.pos_x;
      pos_r[1] <= in_ch.pos_y;
      pos_r[2] <= in_ch.pos_z;
    end
    if (cell_we) cell_r[axis_r] <= cell_nxt;
    key_r   <= key_nxt;
    mid_r   <= mid_nxt;
    start_r <= start_nxt;
    run_r   <= run_nxt;
    st_r    <= st_nxt;
    res_r   <= res_nxt;
  end

  assign out_ch.valid   = ovalid_r;
  assign out_ch.id_out  = res_r.id_out;
  assign out_ch.status  = res_r.status;
  assign out_ch.last    = res_r.last;
  assign out_ch.key_out = res_r.key_out;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_CMP) |-> (mid_r >= lo_r && mid_r < hi_r))
    else $error("probe outside search window");
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_ID) |-> cnt_r <= run_r)
    else $error("emitted more IDs than run");

endmodule
`default_nettype wire

/* tb/sv/scqe_checker.sv */
// ----------------------------------------------------------------------------
// scqe_checker
// Watches the configuration port and both channels of the query engine,
// keeps its own copy of the tables and registers, predicts the results of
// every accepted query and compares each delivered result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module scqe_checker
  import scqe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  scqe_in_if                         in_ch,
  scqe_out_if                        out_ch,
  output int                         fail_cnt,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] id_out;
    status_t     status;
    logic        last;
    logic [62:0] key_out;
  } cell_result_t;

  // Shadow registers
  logic [31:0] box_x, box_y, box_z, cell_sz;
  logic [12:0] ent_cnt;
  logic [16:0] id_cnt;

  // Shadow tables
  logic [62:0] tab_key   [ENTRY_DEPTH];
  logic [15:0] tab_start [ENTRY_DEPTH];
  logic [6:0]  tab_run   [ENTRY_DEPTH];
  logic [31:0] id_mem    [ID_DEPTH];

  cell_result_t due_q[$];

  // Cell coordinate of one axis: floor of offset over cell size, clamped
  function automatic logic [20:0] axis_cell(logic [31:0] pos, logic [31:0] bmin,
                                            logic [31:0] cs);
    longint          d;
    longint unsigned q;
    d = longint'($signed(pos)) - longint'($signed(bmin));
    if (cs == 0 || d <= 0) return '0;
    q = longint'(d) / longint'({32'd0, cs});
    if (q > 64'h1fffff) return 21'h1fffff;
    return q[20:0];
  endfunction

  function automatic logic [62:0] zkey(logic [20:0] x, logic [20:0] y, logic [20:0] z);
    logic [62:0] k;
    k = '0;
    for (int i = 0; i < 21; i++) begin
      k[3*i]   = x[i];
      k[3*i+1] = y[i];
      k[3*i+2] = z[i];
    end
    return k;
  endfunction

  task automatic lookup_cell(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic [62:0]  k;
    int           lo, hi, mid, ne, ni, st, rn;
    bit           hit;
    cell_result_t r;
    k = zkey(axis_cell(px, box_x, cell_sz), axis_cell(py, box_y, cell_sz),
             axis_cell(pz, box_z, cell_sz));
    ne = (ent_cnt > ENTRY_DEPTH) ? ENTRY_DEPTH : int'(ent_cnt);
    ni = (id_cnt > ID_DEPTH) ? ID_DEPTH : int'(id_cnt);
    lo = 0;
    hi = ne;
    mid = 0;
    hit = 0;
    while (lo < hi) begin
      mid = lo + (hi - 1 - lo) / 2;
      if (tab_key[mid] == k) begin
        hit = 1;
        break;
      end else if (tab_key[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    r.id_out = '0;
    r.last = 1'b1;
    r.key_out = k;
    if (!hit) begin
      r.status = ST_NOTFOUND;
      due_q.push_back(r);
      return;
    end
    st = int'(tab_start[mid]);
    rn = int'(tab_run[mid]);
    if (rn == 0) begin
      r.status = ST_EMPTY;
      due_q.push_back(r);
    end else if (rn > MAX_IDS_PER_CELL || st >= ni || st + rn > ni) begin
      r.status = ST_BADRANGE;
      due_q.push_back(r);
    end else begin
      for (int n = 0; n < rn; n++) begin
        r.id_out = id_mem[st+n];
        r.status = ST_ID;
        r.last = (n + 1 == rn);
        due_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    cell_result_t e;
    if (!rst_n) begin
      box_x <= '0;
      box_y <= '0;
      box_z <= '0;
      cell_sz <= 32'd65536;
      ent_cnt <= '0;
      id_cnt <= '0;
      fail_cnt <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BBOX_X:    box_x <= cfg_wdata;
          CFG_BBOX_Y:    box_y <= cfg_wdata;
          CFG_BBOX_Z:    box_z <= cfg_wdata;
          CFG_CELL_SIZE: cell_sz <= cfg_wdata;
          CFG_NUM_ENT:   ent_cnt <= cfg_wdata[12:0];
          CFG_NUM_IDS:   id_cnt <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      // input transactions
      if (in_ch.valid && in_ch.ready) begin
        case (mode_t'(in_ch.mode))
          MODE_WR_ENTRY: begin
            if (in_ch.index < ENTRY_DEPTH) begin
              tab_key[in_ch.index[11:0]] = in_ch.cell_key;
              tab_start[in_ch.index[11:0]] = in_ch.id_start;
              tab_run[in_ch.index[11:0]] = in_ch.id_run;
            end
          end
          MODE_WR_ID:  id_mem[in_ch.index] = in_ch.traj_id;
          MODE_QUERY:  lookup_cell(in_ch.pos_x, in_ch.pos_y, in_ch.pos_z);
          default: ;
        endcase
      end
      // result transactions
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%t unexpected result id=%h st=%0d last=%b key=%h", $realtime,
                     out_ch.id_out, out_ch.status, out_ch.last, out_ch.key_out);
          fail_cnt <= fail_cnt + 1;
        end else begin
          e = due_q.pop_front();
          if (out_ch.id_out !== e.id_out || out_ch.status !== e.status ||
              out_ch.last !== e.last || out_ch.key_out !== e.key_out) begin
            if (fail_cnt < 10)
              $display({"%t result mismatch: exp id=%h st=%0d last=%b key=%h,",
                        " got id=%h st=%0d last=%b key=%h"},
                       $realtime, e.id_out, e.status, e.last, e.key_out,
                       out_ch.id_out, out_ch.status, out_ch.last, out_ch.key_out);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
    pending <= due_q.size();
  end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the spatial cell query engine: loads sorted cell
// tables and ID stores under several register settings, sends directed and
// random queries with random idling on both sides, and reports the checker's
// outcome.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import scqe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 6000;
  localparam int SETTLE_CYC  = 300;
  localparam int HOLD_CYC    = 600;

  typedef struct {
    mode_t       mode;
    logic [15:0] index;
    logic [62:0] cell_key;
    logic [15:0] id_start;
    logic [6:0]  id_run;
    logic [31:0] traj_id;
    logic [31:0] pos_x, pos_y, pos_z;
  } req_t;

  logic clk, rst_n, cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int   fail_cnt, pending, quiet_cnt;
  bit   calm, hold_req;

  logic [62:0] key_tab [ENTRY_DEPTH];

  scqe_in_if  in_ch();
  scqe_out_if out_ch();

  spatial_cell_query_engine uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  scqe_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
    .fail_cnt(fail_cnt), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Result side: random back-pressure plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [62:0] zkey(logic [20:0] x, logic [20:0] y, logic [20:0] z);
    logic [62:0] k;
    k = '0;
    for (int i = 0; i < 21; i++) begin
      k[3*i]   = x[i];
      k[3*i+1] = y[i];
      k[3*i+2] = z[i];
    end
    return k;
  endfunction

  function automatic logic [20:0] axis_of(logic [62:0] k, int sel);
    logic [20:0] c;
    for (int i = 0; i < 21; i++) c[i] = k[3*i+sel];
    return c;
  endfunction

  // All fields random so every payload bit toggles
  function automatic req_t noise_req(mode_t m);
    req_t r;
    r.mode = m;
    r.index = 16'($urandom);
    r.cell_key = 63'({$urandom, $urandom});
    r.id_start = 16'($urandom);
    r.id_run = 7'($urandom);
    r.traj_id = $urandom;
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.pos_z = $urandom;
    return r;
  endfunction

  function automatic req_t query_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    req_t r;
    r = noise_req(MODE_QUERY);
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    return r;
  endfunction

  function automatic req_t entry_req(int idx, logic [62:0] k, int st, int rn);
    req_t r;
    r = noise_req(MODE_WR_ENTRY);
    r.index = 16'(idx);
    r.cell_key = k;
    r.id_start = 16'(st);
    r.id_run = 7'(rn);
    return r;
  endfunction

  // Ignored traffic: mode 3 or an entry write past the table
  function automatic req_t ignored_req();
    req_t r;
    if ($urandom_range(1)) r = noise_req(MODE_NONE);
    else begin
      r = noise_req(MODE_WR_ENTRY);
      r.index = 16'($urandom_range(16'hffff, ENTRY_DEPTH));
    end
    return r;
  endfunction

  task automatic send(req_t r);
    while (!calm && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= r.mode;
    in_ch.index <= r.index;
    in_ch.cell_key <= r.cell_key;
    in_ch.id_start <= r.id_start;
    in_ch.id_run <= r.id_run;
    in_ch.traj_id <= r.traj_id;
    in_ch.pos_x <= r.pos_x;
    in_ch.pos_y <= r.pos_y;
    in_ch.pos_z <= r.pos_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drain results, then let trailing writes finish before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                              logic [31:0] cs, logic [31:0] ne, logic [31:0] ni);
    logic [31:0] vals[6];
    vals = '{bx, by, bz, cs, ne, ni};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_ids(int cnt);
    req_t r;
    for (int i = 0; i < cnt; i++) begin
      r = noise_req(MODE_WR_ID);
      r.index = 16'(i);
      send(r);
    end
  endtask

  // One load-and-query pass under one register setting
  task automatic run_phase(int n_ent, logic [31:0] ne_reg, logic [31:0] ni_reg,
                           int w_ids, logic [31:0] cs, logic [31:0] bx,
                           logic [31:0] by, logic [31:0] bz, int n_q,
                           int gap_bits, bit squeeze);
    logic [62:0] k;
    logic [20:0] cx, cy, cz;
    longint      px, py, pz, fr;
    int          ni, rn, st, lo_s, sel, i;
    settle();
    program_regs(bx, by, bz, cs, ne_reg, ni_reg);
    ni = (ni_reg > ID_DEPTH) ? int'(ID_DEPTH) : int'(ni_reg[16:0]);
    load_ids(w_ids);
    // sorted keys, top entry pinned to the all-ones key
    k = 63'($urandom_range(1));
    for (i = 0; i < n_ent; i++) begin
      if (i > 0)
        k = 63'(k + 64'd1 + ({$urandom, $urandom} & ((64'd1 << gap_bits) - 64'd1)));
      if (i == n_ent - 1 && i > 0) k = {KEY_W{1'b1}};
      key_tab[i] = k;
      sel = $urandom_range(99);
      if (sel < 70 && w_ids > 0) begin
        rn = $urandom_range((w_ids < 64) ? w_ids : 64, 1);
        st = $urandom_range(w_ids - rn, 0);
      end else if (sel < 80 || (sel < 70)) begin
        rn = 0;
        st = $urandom;
      end else if (sel < 90) begin
        rn = $urandom_range(127, 65);
        st = $urandom;
      end else begin
        rn = $urandom_range(64, 2);
        lo_s = ni - rn + 1;
        if (lo_s < 0) lo_s = 0;
        st = $urandom_range(16'hffff, lo_s);
      end
      send(entry_req(i, k, st, rn));
      if ($urandom_range(15) == 0) send(ignored_req());
    end
    if (squeeze) hold_req = 1;
    // queries
    i = 0;
    while (i < n_q) begin
      sel = $urandom_range(99);
      if (sel < 65 && n_ent > 0) begin
        k = key_tab[$urandom_range(n_ent - 1)];
        cx = axis_of(k, 0);
        cy = axis_of(k, 1);
        cz = axis_of(k, 2);
        if (sel >= 50) cx = cx + 21'd1;
        fr = (cs == 0) ? 0 : longint'($urandom % cs);
        px = longint'($signed(bx)) + longint'(cx) * longint'(cs) + fr;
        py = longint'($signed(by)) + longint'(cy) * longint'(cs) + fr;
        pz = longint'($signed(bz)) + longint'(cz) * longint'(cs) + fr;
        send(query_at(px[31:0], py[31:0], pz[31:0]));
        i++;
      end else if (sel < 80) begin
        send(noise_req(MODE_QUERY));
        i++;
      end else if (sel < 90) begin
        send(query_at($urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                      $urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                      $urandom_range(1) ? 32'h7fffffff : 32'h80000000));
        i++;
      end else begin
        send(ignored_req());
      end
    end
  endtask

  // Short directed table: empty cell, bad ranges, full 64-ID cell, top key
  task automatic directed();
    logic [62:0] k5;
    req_t        r;
    settle();
    program_regs(32'd0, 32'd0, 32'd0, 32'd1, 32'd6, 32'd128);
    load_ids(64);
    k5 = zkey(21'd5, 21'd5, 21'd5);
    send(entry_req(0, 63'd0, 0, 64));
    send(entry_req(1, 63'd1, 7, 0));
    send(entry_req(2, 63'd2, 126, 3));
    send(entry_req(3, 63'd4, 0, 65));
    send(entry_req(4, k5, 10, 5));
    send(entry_req(5, {KEY_W{1'b1}}, 20, 2));
    r = entry_req(16'hffff, {KEY_W{1'b1}}, 16'hffff, 7'h7f);
    send(r);
    send(noise_req(MODE_NONE));
    send(query_at(32'd0, 32'd0, 32'd0));
    send(query_at(32'd1, 32'd0, 32'd0));
    send(query_at(32'd0, 32'd1, 32'd0));
    send(query_at(32'd0, 32'd0, 32'd1));
    send(query_at(32'd5, 32'd5, 32'd5));
    send(query_at(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(query_at(-32'sd5, -32'sd5, -32'sd5));
    send(query_at(32'h80000000, 32'h80000000, 32'h80000000));
    send(query_at(32'd3, 32'd0, 32'd0));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NONE;
    in_ch.index = '0;
    in_ch.cell_key = '0;
    in_ch.id_start = '0;
    in_ch.id_run = '0;
    in_ch.traj_id = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    calm = 0;
    hold_req = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    run_phase(30, 30, 40, 40, 32'd1, 32'd0, 32'd0, 32'd0, 30, 6, 0);
    run_phase(20, 20, 32'h1ffff, 30, 32'h10000, 32'h80000000,
              32'hfff00000, 32'h80001234, 30, 48, 1);
    calm = 1;
    run_phase(8, 8, 0, 0, 32'd0, $urandom, $urandom, $urandom, 10, 4, 0);
    calm = 0;
    run_phase(4, 0, 64, 0, 32'hffffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 8, 3, 0);
    run_phase(16, 16, 65536, 30, 32'd3, -32'sd1000, -32'sd1000, -32'sd1000,
              16, 9, 0);
    settle();

    if (fail_cnt == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
